>>> src/assert_macros.svh
// Assertion helper macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define JSU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle property violated");

// Next-cycle implication, disabled while reset is asserted.
`define JSU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle property violated");

`endif

>>> src/jsu_pkg.sv
// ---------------------------------------------------------------------------
// jsu_pkg
// Shared types, codes and UTF-8 helpers for the JSON string unescaper.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

  // result kinds on the output channel
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  localparam logic [20:0] CP_SUPP_BASE = 21'h10000;

  typedef enum logic [1:0] {
    TERM_NONE,
    TERM_END,
    TERM_ERR
  } term_e;

  // One decoded input item: an optional released high surrogate, an
  // optional raw byte or code point, and an optional end/error marker.
  typedef struct packed {
    logic        a_vld;
    logic [20:0] a_cp;
    logic        b_vld;
    logic        b_raw;
    logic [20:0] b_cp;
    term_e       term;
    logic [15:0] count;
  } cmd_t;

  function automatic logic [2:0] utf8_len(input logic [20:0] cp);
    logic [2:0] n;
    if (cp < 21'h80) begin
      n = 3'd1;
    end else if (cp < 21'h800) begin
      n = 3'd2;
    end else if (cp < 21'h10000) begin
      n = 3'd3;
    end else begin
      n = 3'd4;
    end
    return n;
  endfunction

  function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] idx);
    logic [2:0] n;
    logic [7:0] r;
    n = utf8_len(cp);
    r = 8'h00;
    unique case (n)
      3'd1: r = cp[7:0];
      3'd2: r = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
      3'd3: begin
        unique case (idx)
          2'd0:    r = {4'b1110, cp[15:12]};
          2'd1:    r = {2'b10, cp[11:6]};
          default: r = {2'b10, cp[5:0]};
        endcase
      end
      default: begin
        unique case (idx)
          2'd0: r = {5'b11110, cp[20:18]};
          2'd1: r = {2'b10, cp[17:12]};
          2'd2: r = {2'b10, cp[11:6]};
          2'd3: r = {2'b10, cp[5:0]};
        endcase
      end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> src/jsu_if.sv
// ---------------------------------------------------------------------------
// jsu_in_if / jsu_out_if
// Valid/ready channels for raw input bytes and decoded results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface jsu_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [1:0]  kind;
  logic [15:0] byte_count;
  logic        last;

  modport source (output valid, output out_byte, output kind, output byte_count,
                  output last, input ready);
  modport sink   (input valid, input out_byte, input kind, input byte_count,
                  input last, output ready);
endinterface

`default_nettype wire

>>> src/jsu_front.sv
// ---------------------------------------------------------------------------
// jsu_front
// Escape decoder: takes one raw byte per transfer, tracks escape, hex and
// surrogate-pair state, and emits one command per byte that yields output.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jsu_front #(
  parameter int COUNT_BITS = 16
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  jsu_in_if.sink        in_i,
  input  wire logic     full_i,
  output logic          push_o,
  output jsu_pkg::cmd_t cmd_o
);

  localparam int CntW = (COUNT_BITS < 16) ? COUNT_BITS : 16;
  localparam int SumW = CntW + 3;
  localparam logic [SumW-1:0] CntMax = SumW'((64'd1 << CntW) - 64'd1);

  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChBsl   = 8'h5C;
  localparam logic [7:0] ChU     = 8'h75;

  typedef enum logic [2:0] {
    MODE_PLAIN,
    MODE_ESC,
    MODE_HEX,
    MODE_PAIR_BSL,
    MODE_PAIR_U,
    MODE_HEX2
  } mode_e;

  mode_e            mode_q, mode_d;
  logic [15:0]      hex_q, hex_d;
  logic [1:0]       dig_q, dig_d;
  logic [9:0]       held_q, held_d;
  logic [CntW-1:0]  len_q, len_d;

  logic [7:0]       b;
  logic [15:0]      acc;
  logic             done;
  logic             do_plain, do_esc, do_first, clr;
  logic             accept;
  logic [2:0]       n_a, n_b;
  logic [SumW-1:0]  sum, len_sat;
  jsu_pkg::cmd_t    cmd;

  function automatic logic [3:0] nibble(input logic [7:0] c);
    logic [7:0] l;
    logic [3:0] r;
    l = c | 8'h20;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = c[3:0];
    end else if (l >= 8'h61 && l <= 8'h66) begin
      r = 4'(l - 8'h57);
    end else begin
      r = 4'h0;
    end
    return r;
  endfunction

  assign b      = in_i.in_byte;
  assign acc    = {hex_q[11:0], nibble(b)};
  assign done   = (dig_q == 2'd3);
  assign accept = in_i.valid && in_i.ready;
  assign in_i.ready = !full_i;

  always_comb begin
    mode_d   = mode_q;
    hex_d    = hex_q;
    dig_d    = dig_q;
    held_d   = held_q;
    do_plain = 1'b0;
    do_esc   = 1'b0;
    do_first = 1'b0;
    clr      = 1'b0;
    cmd      = '0;

    if (in_i.end_of_input) begin
      cmd.term = jsu_pkg::TERM_ERR;
      clr      = 1'b1;
    end else begin
      unique case (mode_q)
        MODE_ESC: do_esc = 1'b1;
        MODE_HEX: begin
          hex_d = acc;
          if (done) begin
            dig_d    = 2'd0;
            do_first = 1'b1;
          end else begin
            dig_d = dig_q + 2'd1;
          end
        end
        MODE_PAIR_BSL: begin
          if (b == ChBsl) begin
            mode_d = MODE_PAIR_U;
          end else begin
            cmd.a_vld = 1'b1;
            cmd.a_cp  = {5'b00000, 6'b110110, held_q};
            do_plain  = 1'b1;
          end
        end
        MODE_PAIR_U: begin
          if (b == ChU) begin
            mode_d = MODE_HEX2;
            hex_d  = 16'h0000;
            dig_d  = 2'd0;
          end else begin
            cmd.a_vld = 1'b1;
            cmd.a_cp  = {5'b00000, 6'b110110, held_q};
            do_esc    = 1'b1;
          end
        end
        MODE_HEX2: begin
          hex_d = acc;
          if (done) begin
            dig_d = 2'd0;
            if (acc[15:10] == 6'b110111) begin
              cmd.b_vld = 1'b1;
              cmd.b_cp  = jsu_pkg::CP_SUPP_BASE + {1'b0, held_q, acc[9:0]};
              mode_d    = MODE_PLAIN;
            end else begin
              cmd.a_vld = 1'b1;
              cmd.a_cp  = {5'b00000, 6'b110110, held_q};
              do_first  = 1'b1;
            end
          end else begin
            dig_d = dig_q + 2'd1;
          end
        end
        default: do_plain = 1'b1;
      endcase
    end

    if (do_plain) begin
      mode_d = MODE_PLAIN;
      if (b == ChQuote) begin
        cmd.term = jsu_pkg::TERM_END;
        clr      = 1'b1;
      end else if (b == ChBsl) begin
        mode_d = MODE_ESC;
      end else begin
        cmd.b_vld = 1'b1;
        cmd.b_raw = 1'b1;
        cmd.b_cp  = {13'h0000, b};
      end
    end

    if (do_esc) begin
      mode_d    = MODE_PLAIN;
      cmd.b_vld = 1'b1;
      cmd.b_raw = 1'b1;
      unique case (b)
        8'h6E:   cmd.b_cp = 21'h0A;
        8'h74:   cmd.b_cp = 21'h09;
        8'h72:   cmd.b_cp = 21'h0D;
        8'h62:   cmd.b_cp = 21'h08;
        8'h66:   cmd.b_cp = 21'h0C;
        ChU: begin
          cmd.b_vld = 1'b0;
          mode_d    = MODE_HEX;
          hex_d     = 16'h0000;
          dig_d     = 2'd0;
        end
        default: cmd.b_cp = {13'h0000, b};
      endcase
    end

    if (do_first) begin
      if (acc[15:10] == 6'b110110) begin
        held_d = acc[9:0];
        mode_d = MODE_PAIR_BSL;
      end else begin
        cmd.b_vld = 1'b1;
        cmd.b_cp  = {5'b00000, acc};
        mode_d    = MODE_PLAIN;
      end
    end

    // saturating length after this item's bytes
    n_a = cmd.a_vld ? 3'd3 : 3'd0;
    n_b = !cmd.b_vld ? 3'd0 : (cmd.b_raw ? 3'd1 : jsu_pkg::utf8_len(cmd.b_cp));
    sum = SumW'(len_q) + SumW'(n_a) + SumW'(n_b);
    len_sat   = (sum > CntMax) ? CntMax : sum;
    cmd.count = (cmd.term == jsu_pkg::TERM_END) ? 16'(len_sat) : 16'h0000;
    len_d     = CntW'(len_sat);

    if (clr) begin
      mode_d = MODE_PLAIN;
      hex_d  = 16'h0000;
      dig_d  = 2'd0;
      held_d = 10'h000;
      len_d  = '0;
    end
  end

  assign cmd_o  = cmd;
  assign push_o = accept && (cmd.a_vld || cmd.b_vld || (cmd.term != jsu_pkg::TERM_NONE));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_PLAIN;
      hex_q  <= 16'h0000;
      dig_q  <= 2'd0;
      held_q <= 10'h000;
      len_q  <= '0;
    end else if (accept) begin
      mode_q <= mode_d;
      hex_q  <= hex_d;
      dig_q  <= dig_d;
      held_q <= held_d;
      len_q  <= len_d;
    end
  end

endmodule

`default_nettype wire

>>> src/jsu_fifo.sv
// ---------------------------------------------------------------------------
// jsu_fifo
// Two-entry command queue between the decoder and the byte sequencer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jsu_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire jsu_pkg::cmd_t  data_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output jsu_pkg::cmd_t       head_o,
  output logic                empty_o
);

  localparam int Depth = 2;  // power of two: pointers wrap naturally
  localparam int PtrW  = $clog2(Depth);

  jsu_pkg::cmd_t   mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;

  assign full_o  = (cnt_q == (PtrW + 1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> src/jsu_back.sv
// ---------------------------------------------------------------------------
// jsu_back
// Byte sequencer: walks the head command one result per cycle into the
// output register while it is empty or being read, UTF-8 encoding code points on the way.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jsu_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire jsu_pkg::cmd_t  head_i,
  input  wire logic           empty_i,
  output logic                pop_o,
  jsu_out_if.source           out_o
);

  typedef enum logic [1:0] {
    PH_A,
    PH_B,
    PH_T
  } phase_e;

  phase_e      phase_q, eff;
  logic [1:0]  idx_q;
  logic        valid_q;
  logic [7:0]  byte_q, res_byte;
  logic [1:0]  kind_q, res_kind;
  logic [15:0] count_q, res_count;
  logic        last_q, res_last;

  logic [2:0]  elem_len;
  logic        elem_end, rest, can_load, load;

  always_comb begin
    if (phase_q == PH_A && head_i.a_vld) begin
      eff = PH_A;
    end else if (phase_q != PH_T && head_i.b_vld) begin
      eff = PH_B;
    end else begin
      eff = PH_T;
    end

    res_byte  = 8'h00;
    res_kind  = jsu_pkg::KIND_DATA;
    res_count = 16'h0000;
    unique case (eff)
      PH_A: begin
        elem_len = jsu_pkg::utf8_len(head_i.a_cp);
        rest     = head_i.b_vld || (head_i.term != jsu_pkg::TERM_NONE);
        res_byte = jsu_pkg::utf8_byte(head_i.a_cp, idx_q);
      end
      PH_B: begin
        elem_len = head_i.b_raw ? 3'd1 : jsu_pkg::utf8_len(head_i.b_cp);
        rest     = (head_i.term != jsu_pkg::TERM_NONE);
        res_byte = head_i.b_raw ? head_i.b_cp[7:0] : jsu_pkg::utf8_byte(head_i.b_cp, idx_q);
      end
      default: begin
        elem_len  = 3'd1;
        rest      = 1'b0;
        res_kind  = (head_i.term == jsu_pkg::TERM_END) ? jsu_pkg::KIND_END : jsu_pkg::KIND_ERR;
        res_count = head_i.count;
      end
    endcase

    elem_end = ({1'b0, idx_q} == (elem_len - 3'd1));
    res_last = elem_end && !rest;
  end

  assign can_load = !valid_q || out_o.ready;
  assign load     = can_load && !empty_i;
  assign pop_o    = load && res_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= PH_A;
      idx_q   <= 2'd0;
    end else if (load) begin
      valid_q <= 1'b1;
      byte_q  <= res_byte;
      kind_q  <= res_kind;
      count_q <= res_count;
      last_q  <= res_last;
      if (res_last) begin
        phase_q <= PH_A;
        idx_q   <= 2'd0;
      end else if (elem_end) begin
        phase_q <= (eff == PH_A) ? PH_B : PH_T;
        idx_q   <= 2'd0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  assign out_o.valid      = valid_q;
  assign out_o.out_byte   = byte_q;
  assign out_o.kind       = kind_q;
  assign out_o.byte_count = count_q;
  assign out_o.last       = last_q;

endmodule

`default_nettype wire

>>> src/json_string_unescape.sv
// ---------------------------------------------------------------------------
// json_string_unescape
// JSON string body decoder: raw bytes in, UTF-8 bytes and end markers out.
// ---------------------------------------------------------------------------
// Usage:
//   in_i carries one raw byte per transfer, starting after the opening quote;
//   end_of_input marks the end of the text buffer (byte ignored).
//   out_o carries results: data bytes (kind 0), a closing-quote marker with
//   the saturating byte count (kind 1), or an unterminated-string error
//   (kind 2). last flags the final result produced by one input byte.
//   The first result of a byte is registered in the command queue and then
//   in the output register before it is valid on out_o.
//   Throughput: one input byte per cycle while the queue is not full; a byte
//   that yields N results (N up to 6, e.g. a released surrogate followed by
//   a new code point) sends them through the single output register in turn.
//   A two-entry command queue sits between the decoder and the sequencer,
//   so in_i.ready falls only once two commands are waiting.
//   Reset: queue empty, plain body mode, count zero. After a closing quote
//   or an error the decoder starts a fresh string body.
//   Receiver stall: the output result holds; the queue fills, then in_i
//   stops accepting.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module json_string_unescape #(
  parameter int COUNT_BITS = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  jsu_in_if.sink    in_i,
  jsu_out_if.source out_o
);

  jsu_pkg::cmd_t cmd, head;
  logic          push, full, pop, empty;

  jsu_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_i),
    .full_i(full),
    .push_o(push),
    .cmd_o (cmd)
  );

  jsu_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (cmd),
    .full_o (full),
    .pop_i  (pop),
    .head_o (head),
    .empty_o(empty)
  );

  jsu_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .empty_i(empty),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire

>>> src/jsu_checker.sv
// ---------------------------------------------------------------------------
// jsu_checker
// Port-level properties of the JSON string decoder, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module jsu_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [7:0]  out_byte_i,
  input wire logic [1:0]  out_kind_i,
  input wire logic [15:0] out_count_i,
  input wire logic        out_last_i
);

  `JSU_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_byte_i) && $stable(out_kind_i) && $stable(out_count_i) && $stable(out_last_i))
  `JSU_ASSERT_IMPL(a_marker_last, clk_i, rst_ni, out_valid_i && (out_kind_i != jsu_pkg::KIND_DATA), out_last_i && (out_byte_i == 8'h00))
  `JSU_ASSERT_IMPL(a_data_nocount, clk_i, rst_ni, out_valid_i && (out_kind_i == jsu_pkg::KIND_DATA), out_count_i == 16'h0000)
  `JSU_ASSERT_IMPL(a_backpressure, clk_i, rst_ni, !in_ready_i, out_valid_i)

endmodule

bind json_string_unescape jsu_checker u_jsu_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_ready_i (in_i.ready),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .out_byte_i (out_o.out_byte),
  .out_kind_i (out_o.kind),
  .out_count_i(out_o.byte_count),
  .out_last_i (out_o.last)
);

`default_nettype wire
